@@ rtl/asz_pkg.sv @@
// Shared types and constants for the adaptive stretch zone detector.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package asz_pkg;

   // configuration register widths and reset values
   localparam int SETTLE_SPAN_WIDTH = 13;
   localparam int PCT_WIDTH         = 7;
   localparam int CSR_DATA_WIDTH    = 13;
   localparam int CSR_ADDR_WIDTH    = 2;

   localparam logic [SETTLE_SPAN_WIDTH-1:0] SETTLE_SPAN_RESET = 13'd100;
   localparam logic [PCT_WIDTH-1:0]         HIGH_PCT_RESET    = 7'd67;
   localparam logic [PCT_WIDTH-1:0]         LOW_PCT_RESET     = 7'd33;

   // configuration register indexes
   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_SETTLE_SPAN = 2'd0,
      CSR_HIGH_PCT    = 2'd1,
      CSR_LOW_PCT     = 2'd2
   } csr_index_type;

   // result codes
   localparam int ZONE_WIDTH = 3;
   localparam int RSP_DATA_WIDTH = 8;

   typedef enum logic [ZONE_WIDTH-1:0] {
      ZONE_FIRST        = 3'd0,
      ZONE_CALIBRATING  = 3'd1,
      ZONE_LOW          = 3'd2,
      ZONE_HIGH         = 3'd3,
      ZONE_MIDDLE       = 3'd4,
      ZONE_ENTERED_LOW  = 3'd5,
      ZONE_ENTERED_HIGH = 3'd6
   } zone_type;

   // control flags of the tracker
   typedef struct packed {
      logic awaiting_first;
      logic arm_high_edge;
      logic arm_low_edge;
   } flags_type;

   localparam flags_type FLAGS_RESET = '{awaiting_first: 1'b1,
                                         arm_high_edge:  1'b1,
                                         arm_low_edge:   1'b1};

endpackage

@@ rtl/asz_classify.sv @@
// Per-sample classification and tracker update: next max, min, span, flags and zone.
// Depends on asz_pkg.
`timescale 1ns / 1ps

module asz_classify #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  logic [SAMPLE_WIDTH-1:0]               sample,
   input  logic [SAMPLE_WIDTH-1:0]               track_max,
   input  logic [SAMPLE_WIDTH-1:0]               track_min,
   input  logic [SAMPLE_WIDTH-1:0]               span,
   input  asz_pkg::flags_type                    flags,
   input  logic [asz_pkg::SETTLE_SPAN_WIDTH-1:0] settle_span,
   input  logic [asz_pkg::PCT_WIDTH-1:0]         high_pct,
   input  logic [asz_pkg::PCT_WIDTH-1:0]         low_pct,
   output logic [SAMPLE_WIDTH-1:0]               next_max,
   output logic [SAMPLE_WIDTH-1:0]               next_min,
   output logic [SAMPLE_WIDTH-1:0]               next_span,
   output asz_pkg::flags_type                    next_flags,
   output asz_pkg::zone_type                     zone
);
   import asz_pkg::*;

   localparam int CMP_WIDTH    = (SAMPLE_WIDTH > SETTLE_SPAN_WIDTH) ? SAMPLE_WIDTH :
                                                                      SETTLE_SPAN_WIDTH;
   localparam int OFFSET_WIDTH = SAMPLE_WIDTH + 8;
   localparam int LIM_WIDTH    = SAMPLE_WIDTH + PCT_WIDTH;

   // span of hi over lo, zero when lo is above hi
   function automatic logic [SAMPLE_WIDTH-1:0] span_of(input logic [SAMPLE_WIDTH-1:0] hi,
                                                       input logic [SAMPLE_WIDTH-1:0] lo);
      span_of = (hi >= lo) ? (hi - lo) : '0;
   endfunction

   logic                           calibrating;
   logic signed [SAMPLE_WIDTH:0]   diff;
   logic signed [OFFSET_WIDTH-1:0] diff_ext;
   logic signed [OFFSET_WIDTH-1:0] offset_x100;
   logic [LIM_WIDTH-1:0]           hi_lim;
   logic [LIM_WIDTH-1:0]           lo_lim;
   logic                           above_high;
   logic                           below_low;
   logic [SAMPLE_WIDTH-1:0]        cal_max;
   logic [SAMPLE_WIDTH-1:0]        cal_span;

   // calibration continues while span is short of the required step
   assign calibrating = (CMP_WIDTH'(span) < CMP_WIDTH'(settle_span));

   // 100 * (sample - min) by shift and add, against pct * span
   assign diff        = $signed({1'b0, sample}) - $signed({1'b0, track_min});
   assign diff_ext    = OFFSET_WIDTH'(diff);
   assign offset_x100 = (diff_ext <<< 6) + (diff_ext <<< 5) + (diff_ext <<< 2);
   assign hi_lim      = LIM_WIDTH'(high_pct) * LIM_WIDTH'(span);
   assign lo_lim      = LIM_WIDTH'(low_pct) * LIM_WIDTH'(span);
   assign above_high  = offset_x100 > $signed({{(OFFSET_WIDTH-LIM_WIDTH){1'b0}}, hi_lim});
   assign below_low   = offset_x100 < $signed({{(OFFSET_WIDTH-LIM_WIDTH){1'b0}}, lo_lim});

   // calibration widens max first, then min against the widened max
   assign cal_max  = (sample > track_max) ? sample : track_max;
   assign cal_span = (sample > track_max) ? span_of(sample, track_min) : span;

   // next tracker state and zone
   always_comb begin
      next_max   = track_max;
      next_min   = track_min;
      next_span  = span;
      next_flags = flags;
      zone       = ZONE_MIDDLE;
      if (flags.awaiting_first) begin
         next_flags.awaiting_first = 1'b0;
         next_max  = sample;
         next_min  = sample;
         next_span = '0;
         zone      = ZONE_FIRST;
      end else if (calibrating) begin
         next_max  = cal_max;
         next_span = cal_span;
         if (sample < track_min) begin
            next_min  = sample;
            next_span = span_of(cal_max, sample);
         end
         zone = ZONE_CALIBRATING;
      end else if (above_high) begin
         if (flags.arm_high_edge) begin
            next_flags.arm_high_edge = 1'b0;
            next_flags.arm_low_edge  = 1'b1;
            next_span = span_of(track_max, track_min);
            next_max  = sample;
            zone      = ZONE_ENTERED_HIGH;
         end else begin
            if (sample > track_max) begin
               next_max  = sample;
               next_span = span_of(sample, track_min);
            end
            zone = ZONE_HIGH;
         end
      end else if (below_low) begin
         if (flags.arm_low_edge) begin
            next_flags.arm_low_edge  = 1'b0;
            next_flags.arm_high_edge = 1'b1;
            next_span = span_of(track_max, track_min);
            next_min  = sample;
            zone      = ZONE_ENTERED_LOW;
         end else begin
            if (sample < track_min) begin
               next_min  = sample;
               next_span = span_of(track_max, sample);
            end
            zone = ZONE_LOW;
         end
      end
   end

endmodule

@@ rtl/adaptive_stretch_zone_detector.sv @@
// Adaptive stretch zone detector top level: stream ports, config registers, tracker state.
// Path: a request is held in the input register, then classified into the result register,
// which drives rsp_tvalid; a stalled response holds the request in the input register.
// Throughput: one request per cycle while rsp_tready is high; the tracker update loop
// through asz_classify closes between its registers, so requests follow back to back.
// Reset: synchronous, active high; clears both stages, arms both edges, restores
// the config defaults (calibration span 100, high percent 67, low percent 33).
// Depends on asz_pkg and asz_classify.
`timescale 1ns / 1ps

module adaptive_stretch_zone_detector #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,  // sample
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [asz_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,  // zone
   // configuration writes
   input  logic                                csr_we,
   input  logic [asz_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [asz_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import asz_pkg::*;

   logic [SETTLE_SPAN_WIDTH-1:0] settle_span_ff;
   logic [PCT_WIDTH-1:0]         high_pct_ff;
   logic [PCT_WIDTH-1:0]         low_pct_ff;

   logic                      req_valid_ff;
   logic [SAMPLE_WIDTH-1:0]   sample_ff;
   logic                      rsp_valid_ff;
   zone_type                  zone_ff;
   zone_type                  zone_in;

   logic [SAMPLE_WIDTH-1:0]   track_max_ff, track_max_in;
   logic [SAMPLE_WIDTH-1:0]   track_min_ff, track_min_in;
   logic [SAMPLE_WIDTH-1:0]   span_ff, span_in;
   flags_type                 flags_ff, flags_in;

   logic                      advance;

   // move from input register to result register when the result slot is free
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_span_ff <= SETTLE_SPAN_RESET;
         high_pct_ff    <= HIGH_PCT_RESET;
         low_pct_ff     <= LOW_PCT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SETTLE_SPAN: settle_span_ff <= csr_wdata[SETTLE_SPAN_WIDTH-1:0];
            CSR_HIGH_PCT:    high_pct_ff    <= csr_wdata[PCT_WIDTH-1:0];
            CSR_LOW_PCT:     low_pct_ff     <= csr_wdata[PCT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[SAMPLE_WIDTH-1:0];
      end
   end

   // classification of the held sample
   asz_classify #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_classify (
      .sample      (sample_ff),
      .track_max   (track_max_ff),
      .track_min   (track_min_ff),
      .span        (span_ff),
      .flags       (flags_ff),
      .settle_span (settle_span_ff),
      .high_pct    (high_pct_ff),
      .low_pct     (low_pct_ff),
      .next_max    (track_max_in),
      .next_min    (track_min_in),
      .next_span   (span_in),
      .next_flags  (flags_in),
      .zone        (zone_in)
   );

   // tracker state updates once per classified request
   always_ff @(posedge clock) begin
      if (reset) begin
         track_max_ff <= '0;
         track_min_ff <= '0;
         span_ff      <= '0;
         flags_ff     <= FLAGS_RESET;
      end else if (advance) begin
         track_max_ff <= track_max_in;
         track_min_ff <= track_min_in;
         span_ff      <= span_in;
         flags_ff     <= flags_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zone_ff <= zone_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-ZONE_WIDTH){1'b0}}, zone_ff};

endmodule

@@ rtl/asz_checker.sv @@
// Port-level checks for the adaptive stretch zone detector, bound to the top level.
// Depends on asz_pkg and adaptive_stretch_zone_detector.
`timescale 1ns / 1ps

module asz_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [asz_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import asz_pkg::*;

   logic first_seen_ff;

   // tracks whether the first response since reset has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         first_seen_ff <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         first_seen_ff <= 1'b1;
      end
   end

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // first response after reset is the seeding code
   a_first_zone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !first_seen_ff) |-> (rsp_tdata[ZONE_WIDTH-1:0] == ZONE_FIRST))
      else $error("first response is not the first-sample code");

   // only defined codes, padding bits zero
   a_zone_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_WIDTH-1:ZONE_WIDTH] == '0 &&
                      rsp_tdata[ZONE_WIDTH-1:0] != 3'd7))
      else $error("undefined zone code");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // an offered request stays offered until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && !req_tready) |=> req_tvalid)
      else $error("request withdrawn before it was taken");

endmodule

bind adaptive_stretch_zone_detector asz_checker u_asz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
